[sv/sotb_pkg.sv]
// Package for the stop order trigger book: sizes, status codes, FSM states
// and the command/status structs between controller and datapath. No dependencies.
package sotb_pkg;

    localparam int STOP_CAPACITY = 32;
    localparam int PRICE_BITS    = 32;
    localparam int IDX_W         = $clog2(STOP_CAPACITY);
    localparam int PROD_W        = PRICE_BITS + 7;

    typedef logic [PRICE_BITS-1:0] price_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [PROD_W-1:0]     prod_t;

    localparam logic OP_ADD    = 1'b0;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;
    localparam logic KIND_MKT  = 1'b0;

    typedef enum logic [2:0] {
        ST_ADDED  = 3'd0,
        ST_FULL   = 3'd1,
        ST_MARKET = 3'd2,
        ST_LIMIT  = 3'd3,
        ST_REJECT = 3'd4,
        ST_NONE   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_PICK,
        S_LOAD,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic latch;       // capture request, start on sell side
        logic add_commit;  // store order (or refuse) and emit add result
        logic scan_clear;  // restart scan at slot 0
        logic scan_step;   // evaluate current slot, advance
        logic to_buy;      // switch to buy side
        logic release_best;// clear best slot, register collar products
        logic load_pend;   // emit held result (if any), hold new one
        logic finish;      // emit held result as last, or nothing released
    } sotb_cmd_t;

    typedef struct packed {
        logic op;
        logic side;
        logic found;
        logic scan_done;
        logic pend_valid;
        logic out_free;
    } sotb_stat_t;

endpackage

[sv/sotb_if.sv]
// Valid/ready channel interfaces for request and result items.
// Depends on sotb_pkg.
interface sotb_req_if import sotb_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        operation;
    logic        order_side;
    logic        stop_kind;
    logic [31:0] trigger_level;
    logic [31:0] limit_level;
    logic [31:0] order_tag;
    logic [31:0] trade_level;

    modport source (output valid, operation, order_side, stop_kind, trigger_level,
                    limit_level, order_tag, trade_level, input ready);
    modport sink   (input valid, operation, order_side, stop_kind, trigger_level,
                    limit_level, order_tag, trade_level, output ready);
endinterface

interface sotb_res_if import sotb_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        out_side;
    logic [31:0] out_limit;
    logic [31:0] out_tag;
    logic        last_of_run;

    modport source (output valid, status, out_side, out_limit, out_tag, last_of_run,
                    input ready);
    modport sink   (input valid, status, out_side, out_limit, out_tag, last_of_run,
                    output ready);
endinterface

[sv/sotb_ctrl.sv]
// Controller FSM for the stop order trigger book.
// Depends on sotb_pkg.
module sotb_ctrl import sotb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  sotb_stat_t stat,
    output sotb_cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch      = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_ADD;
                end
            end
            S_ADD:
            begin
                if (stat.op != OP_ADD)
                begin
                    state_next = S_SCAN;
                end
                else if (stat.out_free)
                begin
                    cmd.add_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (stat.found)
                begin
                    cmd.release_best = 1'b1;
                    state_next       = S_LOAD;
                end
                else if (stat.side == SIDE_SELL)
                begin
                    cmd.to_buy     = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_LOAD:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.load_pend  = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

[sv/sotb_datapath.sv]
// Datapath: stop table registers, serial trigger scan, collar products,
// held result and output register. Depends on sotb_pkg and sotb_if.
module sotb_datapath import sotb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    sotb_req_if.sink   req,
    sotb_res_if.source res,
    input  sotb_cmd_t  cmd,
    output sotb_stat_t stat
);
    logic        valid_reg [STOP_CAPACITY];
    logic        side_reg  [STOP_CAPACITY];
    logic        kind_reg  [STOP_CAPACITY];
    price_t      trig_reg  [STOP_CAPACITY];
    price_t      lim_reg   [STOP_CAPACITY];
    logic [31:0] tag_reg   [STOP_CAPACITY];
    logic [31:0] arr_reg   [STOP_CAPACITY];
    logic [31:0] counter_reg;

    // captured request
    logic        op_reg, rside_reg, rkind_reg;
    price_t      rtrig_reg, rlim_reg, trade_reg;
    logic [31:0] rtag_reg;

    logic        cur_side_reg;
    idx_t        idx_reg;
    logic        found_reg;
    idx_t        best_idx_reg;
    price_t      best_trig_reg, best_lim_reg;
    logic [31:0] best_age_reg, best_tag_reg;
    logic        best_kind_reg;
    prod_t       prod_lim_reg, prod_trade_reg;

    logic        pend_valid_reg;
    status_t     pend_status_reg;
    logic        pend_side_reg;
    logic [31:0] pend_limit_reg, pend_tag_reg;

    logic        out_valid_reg;
    status_t     out_status_reg;
    logic        out_side_reg, out_last_reg;
    logic [31:0] out_limit_reg, out_tag_reg;

    // lowest free slot
    idx_t        free_idx;
    logic        full;
    always_comb
    begin
        free_idx = '0;
        full     = 1'b1;
        for (int i = STOP_CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
                full     = 1'b0;
            end
        end
    end

    // scan compare on the slot under the index
    price_t      t;
    logic [31:0] age;
    logic        elig, better;
    always_comb
    begin
        t    = trig_reg[idx_reg];
        age  = counter_reg - arr_reg[idx_reg];
        elig = valid_reg[idx_reg] && (side_reg[idx_reg] == cur_side_reg) &&
               ((cur_side_reg == SIDE_SELL) ? (t >= trade_reg) : (t <= trade_reg));
        better = !found_reg ||
                 ((cur_side_reg == SIDE_SELL) ? (t < best_trig_reg) : (t > best_trig_reg)) ||
                 ((t == best_trig_reg) && (age > best_age_reg));
    end

    logic    bad;
    status_t rel_status;
    always_comb
    begin
        bad = (cur_side_reg == SIDE_SELL) ? (prod_lim_reg > prod_trade_reg)
                                          : (prod_lim_reg < prod_trade_reg);
        if (best_kind_reg == KIND_MKT)
        begin
            rel_status = ST_MARKET;
        end
        else
        begin
            rel_status = bad ? ST_REJECT : ST_LIMIT;
        end
    end

    logic out_free;
    logic out_load;
    assign out_free = !out_valid_reg || res.ready;
    // a new result enters the output register this cycle
    assign out_load = cmd.add_commit || cmd.finish || (cmd.load_pend && pend_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STOP_CAPACITY; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            counter_reg    <= '0;
            found_reg      <= 1'b0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && res.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.latch)
            begin
                op_reg         <= req.operation;
                rside_reg      <= req.order_side;
                rkind_reg      <= req.stop_kind;
                rtrig_reg      <= PRICE_BITS'(req.trigger_level);
                rlim_reg       <= PRICE_BITS'(req.limit_level);
                rtag_reg       <= req.order_tag;
                trade_reg      <= PRICE_BITS'(req.trade_level);
                cur_side_reg   <= SIDE_SELL;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.to_buy)
            begin
                cur_side_reg <= SIDE_BUY;
            end
            if (cmd.scan_clear)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.add_commit)
            begin
                if (!full)
                begin
                    valid_reg[free_idx] <= 1'b1;
                    side_reg[free_idx]  <= rside_reg;
                    kind_reg[free_idx]  <= rkind_reg;
                    trig_reg[free_idx]  <= rtrig_reg;
                    lim_reg[free_idx]   <= rlim_reg;
                    tag_reg[free_idx]   <= rtag_reg;
                    arr_reg[free_idx]   <= counter_reg;
                    counter_reg         <= counter_reg + 32'd1;
                end
                out_valid_reg  <= 1'b1;
                out_status_reg <= full ? ST_FULL : ST_ADDED;
                out_side_reg   <= rside_reg;
                out_limit_reg  <= '0;
                out_tag_reg    <= rtag_reg;
                out_last_reg   <= 1'b1;
            end
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + idx_t'(1);
                if (elig && better)
                begin
                    found_reg     <= 1'b1;
                    best_idx_reg  <= idx_reg;
                    best_trig_reg <= t;
                    best_age_reg  <= age;
                    best_lim_reg  <= lim_reg[idx_reg];
                    best_tag_reg  <= tag_reg[idx_reg];
                    best_kind_reg <= kind_reg[idx_reg];
                end
            end
            if (cmd.release_best)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
                prod_lim_reg   <= PROD_W'(best_lim_reg) * PROD_W'(100);
                prod_trade_reg <= PROD_W'(trade_reg) *
                                  ((cur_side_reg == SIDE_SELL) ? PROD_W'(105) : PROD_W'(95));
            end
            if (cmd.load_pend)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    out_status_reg <= pend_status_reg;
                    out_side_reg   <= pend_side_reg;
                    out_limit_reg  <= pend_limit_reg;
                    out_tag_reg    <= pend_tag_reg;
                    out_last_reg   <= 1'b0;
                end
                pend_valid_reg  <= 1'b1;
                pend_status_reg <= rel_status;
                pend_side_reg   <= cur_side_reg;
                pend_limit_reg  <= (best_kind_reg == KIND_MKT) ? 32'd0 : 32'(best_lim_reg);
                pend_tag_reg    <= best_tag_reg;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= 1'b1;
                if (pend_valid_reg)
                begin
                    out_status_reg <= pend_status_reg;
                    out_side_reg   <= pend_side_reg;
                    out_limit_reg  <= pend_limit_reg;
                    out_tag_reg    <= pend_tag_reg;
                end
                else
                begin
                    out_status_reg <= ST_NONE;
                    out_side_reg   <= 1'b0;
                    out_limit_reg  <= '0;
                    out_tag_reg    <= '0;
                end
                pend_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.op         = op_reg;
    assign stat.side       = cur_side_reg;
    assign stat.found      = found_reg;
    assign stat.scan_done  = (idx_reg == idx_t'(STOP_CAPACITY - 1));
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.out_side    = out_side_reg;
    assign res.out_limit   = out_limit_reg;
    assign res.out_tag     = out_tag_reg;
    assign res.last_of_run = out_last_reg;
endmodule

[sv/stop_order_trigger_book_unit.sv]
// Top level of the stop order trigger book: controller plus datapath.
// Depends on sotb_pkg, sotb_if, sotb_ctrl and sotb_datapath.
// Holds up to 32 resting stop orders and handles one request at a time. An add is latched
// in the idle state and writes its result into the output register from the add state,
// which waits for the output register to be free; the unit then returns to idle for the
// next request. A trade scans the table one slot per cycle: each released order costs one
// full pass plus the pick and load states, and each side ends with one pass that finds
// nothing. Results sit in an output register; a stalled result channel holds the scan
// when a further result is ready to go.
module stop_order_trigger_book_unit import sotb_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    sotb_req_if.sink   orders,
    sotb_res_if.source results
);
    sotb_cmd_t  cmd;
    sotb_stat_t stat;

    sotb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (orders.valid),
        .req_ready (orders.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sotb_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (orders),
        .res   (results),
        .cmd   (cmd),
        .stat  (stat)
    );
endmodule

[sim/sotb_tb_if.sv]
// Testbench copy of nothing: the RTL interfaces are reused as they are.
// This file only holds shared testbench constants. Depends on sotb_pkg.
package sotb_tb_pkg;
    import sotb_pkg::*;
    localparam logic OP_TRADE   = 1'b1;
    localparam logic KIND_LIMIT = 1'b1;
    localparam int   RUN_LIMIT  = 2000000;
endpackage

[sim/testbench.sv]
// Self-checking bench for stop_order_trigger_book_unit: a book predictor computes the
// expected result stream per request; monitor compares.
// Depends on sotb_pkg, sotb_tb_pkg, sotb_if.
module testbench;
    import sotb_pkg::*;
    import sotb_tb_pkg::*;

    typedef struct packed {
        logic        operation;
        logic        order_side;
        logic        stop_kind;
        logic [31:0] trigger_level;
        logic [31:0] limit_level;
        logic [31:0] order_tag;
        logic [31:0] trade_level;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic        out_side;
        logic [31:0] out_limit;
        logic [31:0] out_tag;
        logic        last_of_run;
    } fill_t;

    logic clk;
    logic rst_n;
    sotb_req_if orders();
    sotb_res_if results();

    stop_order_trigger_book_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .orders(orders.sink),
        .results(results.source)
    );

    // predictor state
    logic        bk_valid [STOP_CAPACITY];
    logic        bk_side [STOP_CAPACITY];
    logic        bk_kind [STOP_CAPACITY];
    logic [31:0] bk_trig [STOP_CAPACITY];
    logic [31:0] bk_lim [STOP_CAPACITY];
    logic [31:0] bk_tag [STOP_CAPACITY];
    logic [31:0] bk_arr [STOP_CAPACITY];
    logic [31:0] arrival_seq;

    request_t pending_reqs[$];
    fill_t    expected_fills[$];
    int       errors;
    int       cycles;
    int       hold_off;
    bit       pause_tx;
    bit       in_taken;

    function automatic int next_release(logic side, logic [31:0] px);
        int best;
        logic [31:0] best_age;
        logic [31:0] age;
        best = -1;
        best_age = 0;
        for (int i = 0; i < STOP_CAPACITY; i++)
        begin
            if (!bk_valid[i] || bk_side[i] != side)
                continue;
            if (side == SIDE_SELL ? (bk_trig[i] < px) : (bk_trig[i] > px))
                continue;
            age = arrival_seq - bk_arr[i];
            if (best < 0)
            begin
                best = i;
                best_age = age;
            end
            else if ((side == SIDE_SELL ? bk_trig[i] < bk_trig[best]
                                        : bk_trig[i] > bk_trig[best]) ||
                     (bk_trig[i] == bk_trig[best] && age > best_age))
            begin
                best = i;
                best_age = age;
            end
        end
        return best;
    endfunction

    task automatic predict_book(request_t r);
        fill_t f;
        int slot;
        int n;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic bad;
        if (r.operation == OP_ADD)
        begin
            slot = -1;
            for (int i = 0; i < STOP_CAPACITY; i++)
                if (!bk_valid[i] && slot < 0)
                    slot = i;
            f = '{status: (slot < 0) ? ST_FULL : ST_ADDED, out_side: r.order_side,
                  out_limit: 32'd0, out_tag: r.order_tag, last_of_run: 1'b1};
            if (slot >= 0)
            begin
                bk_valid[slot] = 1'b1;
                bk_side[slot] = r.order_side;
                bk_kind[slot] = r.stop_kind;
                bk_trig[slot] = r.trigger_level;
                bk_lim[slot] = r.limit_level;
                bk_tag[slot] = r.order_tag;
                bk_arr[slot] = arrival_seq;
                arrival_seq++;
            end
            expected_fills = {expected_fills, f};
            return;
        end
        n = 0;
        for (int s = 1; s >= 0; s--)
        begin
            forever
            begin
                slot = next_release(s[0], r.trade_level);
                if (slot < 0)
                    break;
                bk_valid[slot] = 1'b0;
                f.out_side = s[0];
                f.out_tag = bk_tag[slot];
                f.last_of_run = 1'b0;
                if (bk_kind[slot] == KIND_MKT)
                begin
                    f.status = ST_MARKET;
                    f.out_limit = 32'd0;
                end
                else
                begin
                    lhs = 64'(bk_lim[slot]) * 100;
                    rhs = 64'(r.trade_level) * (s == 1 ? 105 : 95);
                    bad = (s == 1) ? (lhs > rhs) : (lhs < rhs);
                    f.status = bad ? ST_REJECT : ST_LIMIT;
                    f.out_limit = bk_lim[slot];
                end
                expected_fills = {expected_fills, f};
                n++;
            end
        end
        if (n == 0)
        begin
            f = '{ST_NONE, 1'b0, 32'd0, 32'd0, 1'b1};
            expected_fills = {expected_fills, f};
        end
        else
        begin
            expected_fills[$].last_of_run = 1'b1;
        end
    endtask

    function automatic request_t make_add(logic side, logic kind, logic [31:0] trig,
                                          logic [31:0] lim, logic [31:0] tag);
        return '{OP_ADD, side, kind, trig, lim, tag, $urandom};
    endfunction

    function automatic request_t make_trade(logic [31:0] px);
        return '{OP_TRADE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                 $urandom, $urandom, px};
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // driver: bursts and gaps, changes on falling edge once the held request is taken
    int burst_left;
    int gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orders.valid <= 1'b0;
            orders.operation <= 1'b0;
            orders.order_side <= 1'b0;
            orders.stop_kind <= 1'b0;
            orders.trigger_level <= '0;
            orders.limit_level <= '0;
            orders.order_tag <= '0;
            orders.trade_level <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!orders.valid || in_taken)
        begin
            if (gap_left > 0 || pause_tx || pending_reqs.size() == 0)
            begin
                orders.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                {orders.operation, orders.order_side, orders.stop_kind,
                 orders.trigger_level, orders.limit_level, orders.order_tag,
                 orders.trade_level} <= pending_reqs[0];
                pending_reqs.delete(0);
                orders.valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver stall pattern, plus one long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            results.ready <= 1'b0;
        end
        else
        begin
            results.ready <= (cycles % 600 < 200) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: requests are predicted and results checked at the rising edge
    always @(posedge clk)
    begin
        fill_t got;
        fill_t exp_f;
        in_taken <= rst_n && orders.valid && orders.ready;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (orders.valid && orders.ready)
                predict_book(request_t'({orders.operation, orders.order_side,
                    orders.stop_kind, orders.trigger_level, orders.limit_level,
                    orders.order_tag, orders.trade_level}));
            if (results.valid && results.ready)
            begin
                got = '{status_t'(results.status), results.out_side, results.out_limit,
                        results.out_tag, results.last_of_run};
                if (expected_fills.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, got);
                    errors++;
                end
                else
                begin
                    exp_f = expected_fills[0];
                    expected_fills.delete(0);
                    if (got !== exp_f)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_f, got);
                        errors++;
                    end
                end
            end
            if (cycles > RUN_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || orders.valid || expected_fills.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] px;
        logic [31:0] base;
        int k;
        errors = 0;
        cycles = 0;
        hold_off = 0;
        pause_tx = 1'b0;
        rst_n = 1'b0;
        orders.valid = 1'b0;
        results.ready = 1'b0;
        for (int i = 0; i < STOP_CAPACITY; i++)
            bk_valid[i] = 1'b0;
        arrival_seq = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: nothing, extremes, same level fifo, collars
        pending_reqs = {pending_reqs, make_trade(32'd0)};
        pending_reqs = {pending_reqs, make_add(SIDE_SELL, KIND_LIMIT, 32'hFFFF_FFFF,
                                               32'hFFFF_FFFF, 32'hFFFF_FFFF)};
        pending_reqs = {pending_reqs, make_add(SIDE_BUY, KIND_MKT, 32'd0, 32'd5, 32'd0)};
        pending_reqs = {pending_reqs, make_add(SIDE_SELL, KIND_MKT, 32'd100, 32'd7, 32'd11)};
        pending_reqs = {pending_reqs,
                        make_add(SIDE_SELL, KIND_LIMIT, 32'd100, 32'd105, 32'd12)};
        pending_reqs = {pending_reqs,
                        make_add(SIDE_SELL, KIND_LIMIT, 32'd100, 32'd106, 32'd13)};
        pending_reqs = {pending_reqs, make_add(SIDE_BUY, KIND_LIMIT, 32'd100, 32'd95, 32'd14)};
        pending_reqs = {pending_reqs, make_add(SIDE_BUY, KIND_LIMIT, 32'd100, 32'd94, 32'd15)};
        pending_reqs = {pending_reqs, make_add(SIDE_BUY, KIND_MKT, 32'd90, 32'd1, 32'd16)};
        pending_reqs = {pending_reqs, make_trade(32'd100)};
        pending_reqs = {pending_reqs, make_trade(32'hFFFF_FFFF)};
        pending_reqs = {pending_reqs, make_trade(32'd0)};
        // fill table past full
        for (int i = 0; i < STOP_CAPACITY + 2; i++)
            pending_reqs = {pending_reqs, make_add(i[0], i[1], 32'd500 + 32'(i % 3),
                                                   $urandom, 32'(i))};
        hold_off = 0;
        wait_drained();
        // long receiver hold-off while a big release backs up the output
        pending_reqs = {pending_reqs, make_trade(32'd501)};
        pending_reqs = {pending_reqs, make_add(SIDE_SELL, KIND_MKT, 32'd9, 32'd9, 32'd99)};
        pending_reqs = {pending_reqs, make_trade(32'd9)};
        hold_off = 400;
        wait_drained();

        // random: mostly clustered prices so trades release several orders
        k = 0;
        while (k < 160)
        begin
            base = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(900, 1100);
            if ($urandom_range(0, 4) == 0)
            begin
                px = base;
                pending_reqs = {pending_reqs, make_trade(px)};
            end
            else
            begin
                px = base + $urandom_range(0, 20) - 10;
                pending_reqs = {pending_reqs,
                    make_add(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        px, $urandom_range(0, 3) == 0 ? $urandom
                                                      : (px * $urandom_range(90, 110)) / 100,
                        $urandom)};
            end
            k++;
            if (k == 100)
            begin
                // sender pause until all results are back
                pause_tx = 1'b1;
                wait (!orders.valid && expected_fills.size() == 0);
                pause_tx = 1'b0;
                wait_drained();
            end
            if (k % 40 == 0)
                wait (pending_reqs.size() < 10);
        end
        pending_reqs = {pending_reqs, make_trade(32'd0)};
        pending_reqs = {pending_reqs, make_trade(32'hFFFF_FFFF)};
        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
sv/sotb_pkg.sv
sv/sotb_if.sv
sv/sotb_ctrl.sv
sv/sotb_datapath.sv
sv/stop_order_trigger_book_unit.sv
sim/sotb_tb_if.sv
sim/testbench.sv
